@@ hdl/mfq_pkg.sv @@
// Package for the mbox "From " line quoter: the quoting mark table, mode codes,
// and the job word that the front end hands to the back end.
// No dependencies.
package mfq_pkg;

   // Mode register codes.
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Line feed closes a line; the next byte is at a line start.
   localparam logic [7:0] NEWLINE = 8'h0A;

   // The quoted mark ">From " is six bytes; the bare mark is its tail.
   localparam logic [2:0] MARK_LEN    = 3'd6;
   localparam logic [2:0] BARE_LEN    = 3'd5;
   localparam logic [2:0] QUOTED_BASE = 3'd0;
   localparam logic [2:0] BARE_BASE   = 3'd1;

   // Default number of jobs waiting between the front end and the back end.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One job: a run of mark bytes, optionally followed by one literal byte.
   typedef struct packed {
      logic [2:0] start;
      logic [2:0] len;
      logic       lit;
      logic [7:0] data;
   } job_type;

   // Byte of the quoted mark ">From " at the given position.
   function automatic logic [7:0] mark_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h3E;
         3'd1:    b = 8'h46;
         3'd2:    b = 8'h72;
         3'd3:    b = 8'h6F;
         3'd4:    b = 8'h6D;
         3'd5:    b = 8'h20;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ hdl/mfq_front.sv @@
// Front end of the mbox "From " line quoter: holds the mode register and the
// line-start and match state, and turns each input word into at most one job.
// Depends on mfq_pkg.
module mfq_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data,
   input  logic            req_valid,
   input  logic [7:0]      req_in_byte,
   input  logic            req_flush,
   input  logic            queue_full,
   output logic            push_valid,
   output mfq_pkg::job_type push_job
);
   import mfq_pkg::*;

   logic       mode_ff;
   logic       at_line_start_ff, at_line_start_in;
   logic [2:0] match_count_ff, match_count_in;

   logic       accept;
   logic       job_present;
   logic       hit;
   logic       is_newline;
   logic [2:0] pat_off, pat_len, rep_start, rep_len, pat_idx, next_count;
   job_type    job;

   // Pattern and replacement depend on the direction.
   always_comb begin
      if (mode_ff == MODE_DECODE) begin
         pat_off   = QUOTED_BASE;
         pat_len   = MARK_LEN;
         rep_start = BARE_BASE;
         rep_len   = BARE_LEN;
      end else begin
         pat_off   = BARE_BASE;
         pat_len   = BARE_LEN;
         rep_start = QUOTED_BASE;
         rep_len   = MARK_LEN;
      end
   end

   // Classify the word and build the job it causes.
   always_comb begin
      pat_idx          = match_count_ff + pat_off;
      next_count       = match_count_ff + 3'd1;
      hit              = (match_count_ff < pat_len) && (req_in_byte == mark_byte(pat_idx));
      is_newline       = (req_in_byte == NEWLINE);
      job.start        = pat_off;
      job.len          = match_count_ff;
      job.lit          = 1'b1;
      job.data         = req_in_byte;
      job_present      = 1'b0;
      at_line_start_in = at_line_start_ff;
      match_count_in   = match_count_ff;
      if (req_flush) begin
         // End of stream: release the held prefix, if any.
         job.lit        = 1'b0;
         job_present    = (match_count_ff != 3'd0);
         if (match_count_ff != 3'd0) begin
            at_line_start_in = 1'b0;
         end
         match_count_in = 3'd0;
      end else if (at_line_start_ff || (match_count_ff != 3'd0)) begin
         if (hit) begin
            if (next_count == pat_len) begin
               // Whole mark seen: send the replacement.
               job.start        = rep_start;
               job.len          = rep_len;
               job.lit          = 1'b0;
               job_present      = 1'b1;
               match_count_in   = 3'd0;
               at_line_start_in = 1'b0;
            end else begin
               match_count_in = next_count;
            end
         end else begin
            // Mismatch: held prefix, then this byte.
            job_present      = 1'b1;
            match_count_in   = 3'd0;
            at_line_start_in = is_newline;
         end
      end else begin
         // Mid-line byte passes through.
         job.len          = 3'd0;
         job_present      = 1'b1;
         at_line_start_in = is_newline;
      end
   end

   assign accept     = req_valid && !queue_full;
   assign push_valid = accept && job_present;
   assign push_job   = job;

   // A mode write restarts the filter at a line start.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_ENCODE;
         at_line_start_ff <= 1'b1;
         match_count_ff   <= 3'd0;
      end else if (csr_wr_en) begin
         mode_ff          <= csr_wr_data;
         at_line_start_ff <= 1'b1;
         match_count_ff   <= 3'd0;
      end else if (accept) begin
         at_line_start_ff <= at_line_start_in;
         match_count_ff   <= match_count_in;
      end
   end

`ifndef SYNTHESIS
   // Bytes are only held while the line start is still open.
   a_held_at_line_start: assert property (@(posedge clock) disable iff (reset)
      (match_count_ff != 3'd0) |-> at_line_start_ff)
      else $error("match held outside a line start");

   // The held count never reaches the pattern length.
   a_count_below_pattern: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DECODE) ? (match_count_ff < MARK_LEN) : (match_count_ff < BARE_LEN))
      else $error("match count at or beyond pattern length");
`endif

endmodule

@@ hdl/mfq_queue.sv @@
// Job queue between the front end and the back end of the mbox quoter.
// A small register ring with a fill count. Depends on mfq_pkg.
module mfq_queue #(
   parameter int DEPTH = mfq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  mfq_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output mfq_pkg::job_type head_job
);
   import mfq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   // The front end never pushes into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("push into full job queue");

   // The back end never pops an empty queue.
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty job queue");
`endif

endmodule

@@ hdl/mfq_back.sv @@
// Back end of the mbox quoter: expands each job into output words, one a cycle
// unless rsp_stall holds the registered output stage. Depends on mfq_pkg.
module mfq_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  mfq_pkg::job_type head_job,
   output logic             pop,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run
);
   import mfq_pkg::*;

   logic       busy_ff, busy_in;
   job_type    job_ff, job_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       out_free;
   logic       cur_valid;
   logic       fire;
   job_type    cur;
   job_type    rest;

   // Take one word from the job in hand, or straight from the queue head.
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      cur       = busy_ff ? job_ff : head_job;
      cur_valid = busy_ff || head_valid;
      fire      = out_free && cur_valid;
      rest      = cur;
      if (cur.len != 3'd0) begin
         rsp_out_byte_in = mark_byte(cur.start);
         rsp_last_in     = (cur.len == 3'd1) && !cur.lit;
         rest.start      = cur.start + 3'd1;
         rest.len        = cur.len - 3'd1;
      end else begin
         rsp_out_byte_in = cur.data;
         rsp_last_in     = 1'b1;
      end
      busy_in      = fire ? !rsp_last_in : busy_ff;
      job_in       = fire ? rest : job_ff;
      rsp_valid_in = fire ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   assign pop = fire && !busy_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Job remainder and output word.
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (fire) begin
         rsp_out_byte_ff <= rsp_out_byte_in;
         rsp_last_ff     <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_out_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef SYNTHESIS
   // A job kept in hand always has words left to send.
   a_busy_not_empty: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((job_ff.len != 3'd0) || job_ff.lit))
      else $error("empty job left in hand");

   // A word that is not the last of its run leaves the rest of the job in hand.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> busy_ff)
      else $error("run ended without last word");
`endif

endmodule

@@ hdl/mbox_from_line_quoter_core.sv @@
// Path: an accepted word's job is queued, then sent out through the output register.
// Throughput: one input word per cycle until the input stalls, once the job queue
// between front and back end (QUEUE_DEPTH jobs) is full; the back end sends each
// job's run of up to six words one after another.
// Reset: synchronous; mode returns to encode, the stream restarts at a line start,
// and the job queue and output stage are emptied at once.
module mbox_from_line_quoter_core #(
   parameter int QUEUE_DEPTH = mfq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_flush,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);
   import mfq_pkg::*;

   logic    queue_full;
   logic    push_valid;
   job_type push_job;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   assign req_stall = queue_full;

   // Front end: classify input words into jobs.
   mfq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_flush   (req_flush),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   // Job queue.
   mfq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Back end: expand jobs into output words.
   mfq_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
